// File: rtl/windowed_peak_trough_oscillation_core_macros.svh
// Assertion macros for the peak/trough oscillation core.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef WINDOWED_PEAK_TROUGH_OSCILLATION_CORE_MACROS_SVH
`define WINDOWED_PEAK_TROUGH_OSCILLATION_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define WPTO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("wpto assertion failed");
`define WPTO_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("wpto assertion failed");
`else
`define WPTO_ASSERT(lbl, prop)
`define WPTO_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// File: rtl/wpto_pkg.sv
// Shared constants for the peak/trough oscillation core.
// No dependencies.
`timescale 1ns / 1ps
package wpto_pkg;
  localparam int WINDOW    = 32;
  localparam int HALF      = WINDOW / 2;
  localparam int DEPTH     = WINDOW + 1;
  localparam int CELLS     = 16;
  localparam int CELL_W    = 4;
  localparam int SAMPLE_W  = 24;
  localparam int FILL_W    = $clog2(DEPTH + 1);
  localparam int RAM_DEPTH = CELLS * DEPTH;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);
  localparam int TIME_W    = 48;
  localparam int TICK_W    = 32;
  localparam int TI_W      = 16;
  localparam int SUM_W     = 56;
  localparam int CNT_W     = 32;
  localparam int ISUM_W    = 64;
  localparam int DVD_W     = 64;
endpackage

// File: rtl/wpto_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module wpto_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: rtl/wpto_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on wpto_pkg.
`timescale 1ns / 1ps
module wpto_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [wpto_pkg::DVD_W-1:0] dividend_i,
  input  logic [wpto_pkg::CNT_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [wpto_pkg::DVD_W-1:0] quot_o
);
  import wpto_pkg::*;

  localparam int ITER_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [CNT_W-1:0]  rem_q, rem_d, dsr_q, dsr_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [CNT_W:0]    rem_sh;
  logic              fits;

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_sh = {rem_q, dvd_q[DVD_W-1]};
    fits   = rem_sh >= {1'b0, dsr_q};
    if (start_i) begin
      dvd_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
      cnt_d = ITER_W'(DVD_W);
    end else if (cnt_q != '0) begin
      rem_d = fits ? CNT_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[CNT_W-1:0];
      dvd_d = {dvd_q[DVD_W-2:0], fits};
      cnt_d = cnt_q - ITER_W'(1);
      done_d = (cnt_q == ITER_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
endmodule

// File: rtl/windowed_peak_trough_oscillation_core.sv
// Top level of the windowed peak/trough oscillation core: sequencer, per-cell
// statistics, window RAM and shared divider. Depends on wpto_pkg, wpto_ram,
// wpto_div and the assertion macro header.
`timescale 1ns / 1ps
`include "windowed_peak_trough_oscillation_core_macros.svh"
// One input beat is one sample of one cell. The core handles one beat at a
// time and holds in_stall_o high while it works. A beat passes through accept,
// window write and output load. Once the centre sample exists, the core also
// reads each stored window sample (up to WINDOW+1) for the max/min scan over
// the window RAM through its single read port, then makes the decision and
// the state update. Each non-empty division (mean peak, mean trough, mean
// period) runs on the shared bit-serial divider; an empty one is skipped.
// A finished result sits in the output register; the next input beat is taken
// while it waits, and the core only stalls at its end if the result is still
// not taken. The user must write tick_interval via cfg_we_i/cfg_wdata_i only
// while idle; the block itself does not enforce it.
module windowed_peak_trough_oscillation_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wpto_pkg::TI_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [wpto_pkg::CELL_W-1:0]   cell_req_i,
  input  logic [wpto_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                          tick_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [wpto_pkg::CELL_W-1:0]   cell_out_o,
  output logic                          crit_found_o,
  output logic                          crit_is_peak_o,
  output logic                          crit_merged_o,
  output logic [wpto_pkg::TIME_W-1:0]   crit_time_o,
  output logic [wpto_pkg::SAMPLE_W-1:0] crit_value_o,
  output logic signed [wpto_pkg::SAMPLE_W-1:0] amplitude_o,
  output logic                          amplitude_valid_o,
  output logic [wpto_pkg::TIME_W-1:0]   period_o,
  output logic                          period_valid_o
);
  import wpto_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WRITE  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;
  localparam logic [2:0] ST_DIVS   = 3'd5;
  localparam logic [2:0] ST_DIVW   = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  localparam logic [1:0] SEL_PEAK   = 2'd0;
  localparam logic [1:0] SEL_TROUGH = 2'd1;
  localparam logic [1:0] SEL_PERIOD = 2'd2;

  localparam logic [FILL_W-1:0] LAST_POS = FILL_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] HALF_POS = FILL_W'(HALF);
  localparam int               DIFF_W   = SUM_W + 2;

  // sequencer and item registers
  logic [2:0]          st_q, st_d;
  logic [CELL_W-1:0]   cell_q;
  logic [SAMPLE_W-1:0] samp_q;
  logic [TICK_W-1:0]   tick_cur_q;
  logic [TICK_W-1:0]   tick_q;
  logic [TI_W-1:0]     ti_q;
  logic [FILL_W-1:0]   fill_n_q, rp_q, k_q, rd_k_q;
  logic                rd_v_q;
  logic [SAMPLE_W-1:0] hi_q, lo_q, mid_q;
  logic [TIME_W-1:0]   t_q;
  logic                found_q, pk_q, merged_q;
  logic [1:0]          dsel_q;
  logic [SUM_W-1:0]    mp_q, mt_q;
  logic [DVD_W-1:0]    pq_q;

  // per-cell state
  logic [FILL_W-1:0]   head_q  [CELLS];
  logic [FILL_W-1:0]   fill_q  [CELLS];
  logic                kind_q  [CELLS];
  logic [SAMPLE_W-1:0] lval_q  [CELLS];
  logic [TIME_W-1:0]   ltime_q [CELLS];
  logic [TIME_W-1:0]   ptime_q [CELLS];
  logic [1:0]          pcnt_q  [CELLS];
  logic [SUM_W-1:0]    psum_q  [CELLS];
  logic [SUM_W-1:0]    tsum_q  [CELLS];
  logic [CNT_W-1:0]    ptot_q  [CELLS];
  logic [CNT_W-1:0]    ttot_q  [CELLS];
  logic [ISUM_W-1:0]   isum_q  [CELLS];
  logic [CNT_W-1:0]    itot_q  [CELLS];

  // output register
  logic                out_valid_q;
  logic [CELL_W-1:0]   o_cell_q;
  logic                o_found_q, o_pk_q, o_merged_q, o_av_q, o_pv_q;
  logic [TIME_W-1:0]   o_time_q, o_per_q;
  logic [SAMPLE_W-1:0] o_val_q, o_amp_q;

  logic                in_acc, out_acc, load_out;
  logic [ADDR_W-1:0]   base, waddr, raddr;
  logic [FILL_W-1:0]   cur_head, new_head, cur_fill, new_fill;
  logic                ram_we, rd_issue;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic [TICK_W-1:0]   centre;
  logic [TIME_W-1:0]   prod;
  logic                div_start, div_done;
  logic [DVD_W-1:0]    div_dvd, div_quot;
  logic [CNT_W-1:0]    div_dsr;
  logic [TIME_W-1:0]   ival;
  logic [ISUM_W:0]     isum_add;
  logic signed [DIFF_W-1:0] diff, half_diff;
  logic                amp_ok, per_ok;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_q && !out_stall_i;
  assign load_out = (st_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  assign base     = ADDR_W'(cell_q) * ADDR_W'(DEPTH);
  assign cur_head = head_q[cell_q];
  assign cur_fill = fill_q[cell_q];
  assign new_head = (cur_head == LAST_POS) ? '0 : cur_head + FILL_W'(1);
  assign new_fill = (cur_fill == FILL_W'(DEPTH)) ? cur_fill : cur_fill + FILL_W'(1);
  assign ram_we   = (st_q == ST_WRITE);
  assign waddr    = base + ADDR_W'(new_head);
  assign raddr    = base + ADDR_W'(rp_q);
  assign rd_issue = (st_q == ST_SCAN) && (k_q < fill_n_q);

  wpto_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RAM_DEPTH)
  ) u_win (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (samp_q),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // centre tick clamps at zero during the first half window
  assign centre = (tick_cur_q >= TICK_W'(HALF)) ? tick_cur_q - TICK_W'(HALF) : '0;
  assign prod   = TIME_W'(centre) * TIME_W'(ti_q);

  always_comb begin
    unique case (dsel_q)
      SEL_PEAK: begin
        div_dvd = DVD_W'(psum_q[cell_q]);
        div_dsr = ptot_q[cell_q];
      end
      SEL_TROUGH: begin
        div_dvd = DVD_W'(tsum_q[cell_q]);
        div_dsr = ttot_q[cell_q];
      end
      default: begin
        div_dvd = isum_q[cell_q];
        div_dsr = itot_q[cell_q];
      end
    endcase
  end

  assign div_start = (st_q == ST_DIVS) && (div_dsr != '0);

  wpto_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:   if (in_valid_i) st_d = ST_WRITE;
      ST_WRITE:  st_d = (new_fill > HALF_POS) ? ST_SCAN : ST_DIVS;
      ST_SCAN:   if (!rd_issue && !rd_v_q) st_d = ST_DECIDE;
      ST_DECIDE: st_d = ST_UPDATE;
      ST_UPDATE: st_d = ST_DIVS;
      ST_DIVS: begin
        if (div_start) st_d = ST_DIVW;
        else if (dsel_q == SEL_PERIOD) st_d = ST_DONE;
      end
      ST_DIVW: begin
        if (div_done) st_d = (dsel_q == SEL_PERIOD) ? ST_DONE : ST_DIVS;
      end
      default:   if (load_out) st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      tick_q      <= '0;
      ti_q        <= TI_W'(1);
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      rd_v_q <= rd_issue;
      if (cfg_we_i) ti_q <= cfg_wdata_i;
      if (in_acc && tick_end_i) tick_q <= tick_q + TICK_W'(1);
      if (load_out) out_valid_q <= 1'b1;
      else if (out_acc) out_valid_q <= 1'b0;
    end
  end

  // datapath of the current item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cell_q     <= cell_req_i;
      samp_q     <= sample_i;
      tick_cur_q <= tick_q;
    end
    rd_k_q <= k_q;
    unique case (st_q)
      ST_WRITE: begin
        fill_n_q <= new_fill;
        hi_q     <= samp_q;
        lo_q     <= samp_q;
        mid_q    <= samp_q;
        rp_q     <= (new_head == '0) ? LAST_POS : new_head - FILL_W'(1);
        k_q      <= FILL_W'(1);
        found_q  <= 1'b0;
        pk_q     <= 1'b0;
        merged_q <= 1'b0;
        dsel_q   <= SEL_PEAK;
        mp_q     <= '0;
        mt_q     <= '0;
        pq_q     <= '0;
      end
      ST_SCAN: begin
        if (rd_issue) begin
          k_q  <= k_q + FILL_W'(1);
          rp_q <= (rp_q == '0) ? LAST_POS : rp_q - FILL_W'(1);
        end
        if (rd_v_q) begin
          if (ram_rdata > hi_q) hi_q <= ram_rdata;
          if (ram_rdata < lo_q) lo_q <= ram_rdata;
          if (rd_k_q == HALF_POS) mid_q <= ram_rdata;
        end
      end
      ST_DECIDE: begin
        found_q <= (mid_q == hi_q) || (mid_q == lo_q);
        pk_q    <= (mid_q == hi_q);
        t_q     <= prod;
      end
      ST_UPDATE: begin
        if (found_q && pcnt_q[cell_q] != 2'd0 && kind_q[cell_q] == pk_q) begin
          merged_q <= pk_q ? (mid_q >= lval_q[cell_q]) : (mid_q <= lval_q[cell_q]);
        end
      end
      ST_DIVS: begin
        if (!div_start && dsel_q != SEL_PERIOD) dsel_q <= dsel_q + 2'd1;
      end
      ST_DIVW: begin
        if (div_done) begin
          unique case (dsel_q)
            SEL_PEAK:   mp_q <= div_quot[SUM_W-1:0];
            SEL_TROUGH: mt_q <= div_quot[SUM_W-1:0];
            default:    pq_q <= div_quot;
          endcase
          if (dsel_q != SEL_PERIOD) dsel_q <= dsel_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // interval from the point two back; wraps at 48 bits, sum saturates
  assign ival     = t_q - ptime_q[cell_q];
  assign isum_add = {1'b0, isum_q[cell_q]} + (ISUM_W + 1)'(ival);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CELLS; i++) begin
        head_q[i]  <= '0;
        fill_q[i]  <= '0;
        kind_q[i]  <= 1'b0;
        lval_q[i]  <= '0;
        ltime_q[i] <= '0;
        ptime_q[i] <= '0;
        pcnt_q[i]  <= '0;
        psum_q[i]  <= '0;
        tsum_q[i]  <= '0;
        ptot_q[i]  <= '0;
        ttot_q[i]  <= '0;
        isum_q[i]  <= '0;
        itot_q[i]  <= '0;
      end
    end else begin
      if (st_q == ST_WRITE) begin
        head_q[cell_q] <= new_head;
        fill_q[cell_q] <= new_fill;
      end
      if (st_q == ST_UPDATE && found_q) begin
        if (pcnt_q[cell_q] != 2'd0 && kind_q[cell_q] == pk_q) begin
          // same kind: keep the more extreme point
          if (pk_q ? (mid_q >= lval_q[cell_q]) : (mid_q <= lval_q[cell_q])) begin
            lval_q[cell_q]  <= mid_q;
            ltime_q[cell_q] <= t_q;
          end
        end else begin
          if (pk_q) begin
            if (ptot_q[cell_q] != '1) begin
              psum_q[cell_q] <= psum_q[cell_q] + SUM_W'(mid_q);
              ptot_q[cell_q] <= ptot_q[cell_q] + CNT_W'(1);
            end
          end else if (ttot_q[cell_q] != '1) begin
            tsum_q[cell_q] <= tsum_q[cell_q] + SUM_W'(mid_q);
            ttot_q[cell_q] <= ttot_q[cell_q] + CNT_W'(1);
          end
          if (pcnt_q[cell_q] == 2'd2 && itot_q[cell_q] != '1) begin
            isum_q[cell_q] <= isum_add[ISUM_W] ? '1 : isum_add[ISUM_W-1:0];
            itot_q[cell_q] <= itot_q[cell_q] + CNT_W'(1);
          end
          ptime_q[cell_q] <= ltime_q[cell_q];
          ltime_q[cell_q] <= t_q;
          kind_q[cell_q]  <= pk_q;
          lval_q[cell_q]  <= mid_q;
          if (pcnt_q[cell_q] != 2'd2) pcnt_q[cell_q] <= pcnt_q[cell_q] + 2'd1;
        end
      end
    end
  end

  // halve toward zero: add one to negatives before the shift
  assign diff      = $signed({2'b00, mp_q}) - $signed({2'b00, mt_q});
  assign half_diff = (diff + $signed(DIFF_W'(diff[DIFF_W-1]))) >>> 1;
  assign amp_ok    = (ptot_q[cell_q] != '0) && (ttot_q[cell_q] != '0);
  assign per_ok    = (itot_q[cell_q] != '0);

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_cell_q   <= cell_q;
      o_found_q  <= found_q;
      o_pk_q     <= found_q && pk_q;
      o_merged_q <= found_q && merged_q;
      o_time_q   <= found_q ? t_q : '0;
      o_val_q    <= found_q ? mid_q : '0;
      o_av_q     <= amp_ok;
      o_amp_q    <= amp_ok ? half_diff[SAMPLE_W-1:0] : '0;
      o_pv_q     <= per_ok;
      o_per_q    <= !per_ok ? '0 :
                    (pq_q[DVD_W-1:TIME_W] != '0) ? '1 : pq_q[TIME_W-1:0];
    end
  end

  assign in_stall_o        = (st_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign cell_out_o        = o_cell_q;
  assign crit_found_o      = o_found_q;
  assign crit_is_peak_o    = o_pk_q;
  assign crit_merged_o     = o_merged_q;
  assign crit_time_o       = o_time_q;
  assign crit_value_o      = o_val_q;
  assign amplitude_o       = $signed(o_amp_q);
  assign amplitude_valid_o = o_av_q;
  assign period_o          = o_per_q;
  assign period_valid_o    = o_pv_q;

  `WPTO_ASSERT(a_scan_bound, (st_q == ST_SCAN) |-> (k_q <= fill_n_q))
  `WPTO_ASSERT_NEXT(a_div_latency, div_start, !div_done)
  `WPTO_ASSERT(a_amp_zero, (out_valid_q && !o_av_q) |-> (o_amp_q == '0))
endmodule
